FILE: src/lx200_pkg.sv
// Shared types, character codes and field-parsing helpers for the LX200 command parser.
// No dependencies; every other file in src refers to this package by scoped names.
`default_nettype none

package lx200_pkg;

    // Only message positions 0..11 are ever inspected (exact commands and coordinate fields).
    localparam int STORED_BYTES = 12;
    localparam int IDX_W        = 4;
    localparam int COORD_START  = 3;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam int FIELD_W      = 7;   // two decimal digits, 0..99
    localparam int SUM_W        = 19;  // 99*3600 + 99*60 + 99
    localparam int ANGLE_W      = 24;

    localparam logic [7:0] END_BYTE_RESET = 8'h23;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_C  = 8'h43;
    localparam logic [7:0] CH_UP_D  = 8'h44;
    localparam logic [7:0] CH_UP_G  = 8'h47;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_UP_Q  = 8'h51;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_R  = 8'h72;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_GET_RA  = 3'd1,
        CMD_GET_DEC = 3'd2,
        CMD_SYNC    = 3'd3,
        CMD_SLEW    = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_SET_RA  = 3'd6,
        CMD_SET_DEC = 3'd7
    } cmd_code_t;

    // One classified message, handed from the front end to the back end.
    typedef struct packed {
        cmd_code_t             code;
        logic                  neg;
        logic [FIELD_W-1:0]    hi;
        logic [FIELD_W-1:0]    mid;
        logic [FIELD_W-1:0]    lo;
    } cmd_entry_t;

    localparam int ENTRY_W = $bits(cmd_entry_t);

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Two-character window: skip leading whitespace, then read digits.
    // An absent character stops both the skip and the digit read.
    function automatic logic [FIELD_W-1:0] parse_field(
        input logic       ok0,
        input logic [7:0] c0,
        input logic       ok1,
        input logic [7:0] c1
    );
        logic [FIELD_W-1:0] d0;
        logic [FIELD_W-1:0] d1;
        logic [FIELD_W-1:0] v;
        d0 = FIELD_W'(c0[3:0]);
        d1 = FIELD_W'(c1[3:0]);
        v  = '0;
        if (ok0 && is_ws(c0)) begin
            if (ok1 && is_digit(c1)) begin
                v = d1;
            end
        end else if (ok0 && is_digit(c0)) begin
            if (ok1 && is_digit(c1)) begin
                v = FIELD_W'(d0 * FIELD_W'(10)) + d1;
            end else begin
                v = d0;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/lx200_command_parser.sv
// Top level of the LX200 serial command parser: terminator register plus front end,
// command queue and back end. Depends on lx200_pkg, lx200_front, lx200_queue, lx200_back.
`default_nettype none

// The parser takes one command byte per clock (push while full is low) and emits one
// result per terminator byte on a queue-style output (empty/pop). Exact messages ":GR#",
// ":GD#", ":CM#", ":MS#" and ":Q#" give codes 1..5; anything that starts ":Sr" or ":Sd"
// gives set-RA (6) or set-DEC (7) with the target in whole arc-seconds, and everything
// else gives code 0 with a zero angle. Bytes are taken back to back with no gaps while
// full is low; a result reaches the output ports through the command queue write, the
// field-sum stage and the output register. Up to four classified commands wait in the
// queue between front and back, so full rises only when the consumer has stopped popping
// for a while. The terminator value (cfg_wdata, written with cfg_we) resets to '#';
// change it only while no message is in flight. Exact commands carry '#' and therefore
// only match while the terminator is '#'. KEPT_BYTES sets where the message length count
// saturates.

module lx200_command_parser #(
    parameter int KEPT_BYTES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       command_code,
    output logic signed [23:0] angle_arcsec
);

    logic [7:0] end_byte_reg;
    logic [7:0] end_byte_next;
    logic       accept;

    logic                  entry_push;
    lx200_pkg::cmd_entry_t entry;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    lx200_pkg::cmd_entry_t q_data;

    // Hold the terminator value until software rewrites it.
    assign end_byte_next = cfg_we ? cfg_wdata : end_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_byte_reg <= lx200_pkg::END_BYTE_RESET;
        end
        else
        begin
            end_byte_reg <= end_byte_next;
        end
    end

    // Stall the input only when the command queue has no room.
    assign full   = q_full;
    assign accept = push && !q_full;

    lx200_front #(
        .KEPT_BYTES (KEPT_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .end_byte   (end_byte_reg),
        .entry_push (entry_push),
        .entry      (entry)
    );

    lx200_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (entry_push),
        .wr_data (entry),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_data)
    );

    lx200_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .command_code (command_code),
        .angle_arcsec (angle_arcsec)
    );

endmodule

`default_nettype wire

FILE: src/lx200_front.sv
// Front end: takes bytes, keeps the head of the message and its length, and on the
// terminator classifies the message and extracts the coordinate fields. Uses lx200_pkg.
`default_nettype none

module lx200_front #(
    parameter int KEPT_BYTES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          rx_byte,
    input  wire logic [7:0]          end_byte,
    output logic                     entry_push,
    output lx200_pkg::cmd_entry_t    entry
);

    localparam int LEN_W = $clog2(KEPT_BYTES + 1);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [7:0]       bytes_reg [lx200_pkg::STORED_BYTES];
    logic [lx200_pkg::STORED_BYTES-1:0] present;
    logic             is_end;
    logic [7:0]       byte2;
    logic [7:0]       pos_byte [lx200_pkg::STORED_BYTES];
    logic             m_len3;
    logic             m_len2;
    logic             pref_s;
    lx200_pkg::cmd_code_t code;
    logic [lx200_pkg::FIELD_W-1:0] ra_hi, ra_mid, ra_lo;
    logic [lx200_pkg::FIELD_W-1:0] dec_hi, dec_mid, dec_lo;

    assign is_end     = (rx_byte == end_byte);
    assign entry_push = accept && is_end;

    // A stored position counts as part of the coordinate only when it lies before the terminator.
    always_comb
    begin
        for (int p = 0; p < lx200_pkg::STORED_BYTES; p++)
        begin
            present[p]  = (len_reg > LEN_W'(p));
            pos_byte[p] = bytes_reg[p];
        end
    end

    // Position 2 may be the byte arriving right now.
    assign byte2 = (len_reg == LEN_W'(2)) ? rx_byte : bytes_reg[2];

    assign m_len3 = (len_reg == LEN_W'(3)) && (rx_byte == lx200_pkg::CH_HASH)
                    && (bytes_reg[0] == lx200_pkg::CH_COLON);
    assign m_len2 = (len_reg == LEN_W'(2)) && (rx_byte == lx200_pkg::CH_HASH)
                    && (bytes_reg[0] == lx200_pkg::CH_COLON);
    assign pref_s = (len_reg >= LEN_W'(2)) && (bytes_reg[0] == lx200_pkg::CH_COLON)
                    && (bytes_reg[1] == lx200_pkg::CH_UP_S);

    always_comb
    begin
        code = lx200_pkg::CMD_NONE;
        if (m_len3 && bytes_reg[1] == lx200_pkg::CH_UP_G && bytes_reg[2] == lx200_pkg::CH_UP_R)
        begin
            code = lx200_pkg::CMD_GET_RA;
        end
        else if (m_len3 && bytes_reg[1] == lx200_pkg::CH_UP_G
                 && bytes_reg[2] == lx200_pkg::CH_UP_D)
        begin
            code = lx200_pkg::CMD_GET_DEC;
        end
        else if (m_len3 && bytes_reg[1] == lx200_pkg::CH_UP_C
                 && bytes_reg[2] == lx200_pkg::CH_UP_M)
        begin
            code = lx200_pkg::CMD_SYNC;
        end
        else if (m_len3 && bytes_reg[1] == lx200_pkg::CH_UP_M
                 && bytes_reg[2] == lx200_pkg::CH_UP_S)
        begin
            code = lx200_pkg::CMD_SLEW;
        end
        else if (m_len2 && bytes_reg[1] == lx200_pkg::CH_UP_Q)
        begin
            code = lx200_pkg::CMD_STOP;
        end
        else if (pref_s && byte2 == lx200_pkg::CH_LO_R)
        begin
            code = lx200_pkg::CMD_SET_RA;
        end
        else if (pref_s && byte2 == lx200_pkg::CH_LO_D)
        begin
            code = lx200_pkg::CMD_SET_DEC;
        end
    end

    assign ra_hi   = lx200_pkg::parse_field(present[3], pos_byte[3], present[4], pos_byte[4]);
    assign ra_mid  = lx200_pkg::parse_field(present[6], pos_byte[6], present[7], pos_byte[7]);
    assign ra_lo   = lx200_pkg::parse_field(present[9], pos_byte[9], present[10], pos_byte[10]);
    assign dec_hi  = lx200_pkg::parse_field(present[4], pos_byte[4], present[5], pos_byte[5]);
    assign dec_mid = lx200_pkg::parse_field(present[7], pos_byte[7], present[8], pos_byte[8]);
    assign dec_lo  = lx200_pkg::parse_field(present[10], pos_byte[10],
                                            present[11], pos_byte[11]);

    always_comb
    begin
        entry.code = code;
        entry.neg  = 1'b0;
        entry.hi   = '0;
        entry.mid  = '0;
        entry.lo   = '0;
        case (code)
            lx200_pkg::CMD_SET_RA:
            begin
                entry.hi  = ra_hi;
                entry.mid = ra_mid;
                entry.lo  = ra_lo;
            end
            lx200_pkg::CMD_SET_DEC:
            begin
                entry.neg = present[lx200_pkg::COORD_START]
                            && (pos_byte[lx200_pkg::COORD_START] == lx200_pkg::CH_MINUS);
                entry.hi  = dec_hi;
                entry.mid = dec_mid;
                entry.lo  = dec_lo;
            end
            default:
            begin
                entry.neg = 1'b0;
            end
        endcase
    end

    // Clear on the terminator, otherwise count up and saturate.
    always_comb
    begin
        len_next = len_reg;
        if (accept)
        begin
            if (is_end)
            begin
                len_next = '0;
            end
            else if (len_reg < LEN_W'(KEPT_BYTES))
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (len_reg < LEN_W'(lx200_pkg::STORED_BYTES)))
        begin
            bytes_reg[len_reg[lx200_pkg::IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

FILE: src/lx200_queue.sv
// Short register queue of classified commands between the front end and the back end.
// Uses lx200_pkg for the entry type and depth.
`default_nettype none

module lx200_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire lx200_pkg::cmd_entry_t wr_data,
    output logic                     q_full,
    input  wire logic                rd_en,
    output logic                     q_empty,
    output lx200_pkg::cmd_entry_t    rd_data
);

    lx200_pkg::cmd_entry_t            slot_reg [lx200_pkg::QUEUE_DEPTH];
    logic [lx200_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lx200_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lx200_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                             do_wr, do_rd;

    assign q_full  = (count_reg == lx200_pkg::QCNT_W'(lx200_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + lx200_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + lx200_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + lx200_pkg::QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - lx200_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/lx200_back.sv
// Back end: turns classified fields into an arc-second angle over two stages and holds
// the result for the consumer. Uses lx200_pkg.
`default_nettype none

module lx200_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  wire lx200_pkg::cmd_entry_t q_data,
    output logic                       q_pop,
    input  wire logic                  pop,
    output logic                       empty,
    output logic [2:0]                 command_code,
    output logic signed [lx200_pkg::ANGLE_W-1:0] angle_arcsec
);

    localparam int SW = lx200_pkg::SUM_W;
    localparam int AW = lx200_pkg::ANGLE_W;

    // Stage A: weighted sum of the three fields.
    logic                 a_valid_reg, a_valid_next;
    lx200_pkg::cmd_code_t a_code_reg;
    logic                 a_neg_reg;
    logic [SW-1:0]        a_sum_reg;
    logic [SW-1:0]        sum_calc;

    // Stage B: output register.
    logic                 o_valid_reg, o_valid_next;
    lx200_pkg::cmd_code_t o_code_reg;
    logic signed [AW-1:0] o_angle_reg;
    logic signed [AW-1:0] angle_calc;

    logic o_load, a_load;

    assign o_load = a_valid_reg && (!o_valid_reg || pop);
    assign a_load = !a_valid_reg || o_load;
    assign q_pop  = a_load && !q_empty;

    assign sum_calc = SW'(SW'(q_data.hi) * SW'(3600)) + SW'(SW'(q_data.mid) * SW'(60))
                      + SW'(q_data.lo);

    always_comb
    begin
        case (a_code_reg)
            lx200_pkg::CMD_SET_RA:
            begin
                angle_calc = AW'({a_sum_reg, 4'b0000}) - AW'(a_sum_reg);
            end
            lx200_pkg::CMD_SET_DEC:
            begin
                angle_calc = a_neg_reg ? -AW'(a_sum_reg) : AW'(a_sum_reg);
            end
            default:
            begin
                angle_calc = '0;
            end
        endcase
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_load)
        begin
            a_valid_next = !q_empty;
        end
        o_valid_next = o_valid_reg;
        if (o_load)
        begin
            o_valid_next = 1'b1;
        end
        else if (pop)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_code_reg <= q_data.code;
            a_neg_reg  <= q_data.neg;
            a_sum_reg  <= sum_calc;
        end
        if (o_load)
        begin
            o_code_reg  <= a_code_reg;
            o_angle_reg <= angle_calc;
        end
    end

    assign empty        = !o_valid_reg;
    assign command_code = o_code_reg;
    assign angle_arcsec = o_angle_reg;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking bench for lx200_command_parser: byte stream in, one reply per terminator out.
// Depends on lx200_pkg (command codes, character codes) and the RTL under src.
// Carries its own command predictor, a queue-fed byte driver and a popping reply monitor.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEPT      = 16;      // saturation point of the message length count
    localparam int COORD_POS = 3;       // first coordinate character in a message
    localparam int LATENCY   = 8;       // generous cover for the terminator-to-reply pipe
    localparam int LIMIT     = 400000;  // cycle budget for the whole run

    typedef struct {
        lx200_pkg::cmd_code_t code;
        logic signed [23:0]   angle;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        push = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        pop = 1'b0;
    wire         full;
    wire         empty;
    wire [2:0]   command_code;
    wire signed [23:0] angle_arcsec;

    // Predictor state: a private copy of the message buffer, its length and the terminator.
    logic [7:0]  msg_buf [0:KEPT-1];
    int          msg_len = 0;
    logic [7:0]  term_now = lx200_pkg::END_BYTE_RESET;

    logic [7:0]  tx_bytes [$];          // bytes waiting for the driver
    reply_t      replies_due [$];       // replies predicted but not yet popped
    reply_t      head;
    int          queued = 0;            // bytes handed to the driver so far
    int          stall_pct = 0;         // chance per cycle that either side starts a burst
    int          tx_gap = 0;
    int          rx_stall = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    lx200_command_parser #(
        .KEPT_BYTES(KEPT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .command_code(command_code),
        .angle_arcsec(angle_arcsec)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Command predictor
    // ------------------------------------------------------------------

    // True when the stored message is exactly the given text.
    function automatic bit msg_is(input string pat);
        if (msg_len != pat.len())
            return 1'b0;
        for (int i = 0; i < pat.len(); i++)
            if (msg_buf[i] != pat[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit msg_starts(input logic [7:0] third);
        return msg_len >= 3 && msg_buf[0] == lx200_pkg::CH_COLON &&
               msg_buf[1] == lx200_pkg::CH_UP_S && msg_buf[2] == third;
    endfunction

    // Coordinate character at an offset, or -1 past the terminator or the kept bytes.
    function automatic int coord_at(input int off, input int clen);
        if (off >= clen || COORD_POS + off >= KEPT)
            return -1;
        return int'(msg_buf[COORD_POS + off]);
    endfunction

    // Two-character field: skip leading whitespace, then take digits up to a non-digit.
    function automatic int window_value(input int off, input int clen);
        int i;
        int v;
        int ch;
        i = 0;
        v = 0;
        while (i < 2)
        begin
            ch = coord_at(off + i, clen);
            if (ch == int'(lx200_pkg::CH_SPACE) ||
                (ch >= int'(lx200_pkg::CH_TAB) && ch <= int'(lx200_pkg::CH_CR)))
                i++;
            else
                break;
        end
        while (i < 2)
        begin
            ch = coord_at(off + i, clen);
            if (ch < int'(lx200_pkg::CH_ZERO) || ch > int'(lx200_pkg::CH_NINE))
                break;
            v = v * 10 + ch - int'(lx200_pkg::CH_ZERO);
            i++;
        end
        return v;
    endfunction

    // Advance the predictor by one accepted byte; queue a reply on the terminator.
    function automatic void parse_byte(input logic [7:0] b);
        int                   clen;
        int                   sum;
        lx200_pkg::cmd_code_t code;
        reply_t               r;
        if (msg_len < KEPT)
        begin
            msg_buf[msg_len] = b;
            msg_len++;
        end
        if (b != term_now)
            return;
        clen = (msg_len > COORD_POS + 1) ? msg_len - 1 - COORD_POS : 0;
        code = lx200_pkg::CMD_NONE;
        sum  = 0;
        if (msg_is(":GR#"))
            code = lx200_pkg::CMD_GET_RA;
        else if (msg_is(":GD#"))
            code = lx200_pkg::CMD_GET_DEC;
        else if (msg_is(":CM#"))
            code = lx200_pkg::CMD_SYNC;
        else if (msg_is(":MS#"))
            code = lx200_pkg::CMD_SLEW;
        else if (msg_is(":Q#"))
            code = lx200_pkg::CMD_STOP;
        else if (msg_starts(lx200_pkg::CH_LO_R))
        begin
            // RA is hours:minutes:seconds of time, scaled by 15 into arc-seconds
            code = lx200_pkg::CMD_SET_RA;
            sum  = 15 * (window_value(0, clen) * 3600 + window_value(3, clen) * 60 +
                         window_value(6, clen));
        end
        else if (msg_starts(lx200_pkg::CH_LO_D))
        begin
            // DEC carries its sign ahead of the degree field
            code = lx200_pkg::CMD_SET_DEC;
            sum  = window_value(1, clen) * 3600 + window_value(4, clen) * 60 +
                   window_value(7, clen);
            if (coord_at(0, clen) == int'(lx200_pkg::CH_MINUS))
                sum = -sum;
        end
        r.code  = code;
        r.angle = 24'(sum);
        replies_due.push_back(r);
        msg_len = 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: take one byte per transfer from tx_bytes, with random idle bursts
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            rx_byte <= 8'h00;
            tx_gap  <= 0;
        end
        else
        begin
            if (push && !full)
                parse_byte(rx_byte);
            if (push && full)
            begin
                // hold the byte until the parser takes it
            end
            else if (tx_gap != 0)
            begin
                tx_gap <= tx_gap - 1;
                push   <= 1'b0;
            end
            else if (tx_bytes.size() != 0 && stall_pct != 0 &&
                     $urandom_range(0, 99) < stall_pct)
            begin
                tx_gap <= $urandom_range(0, 7);
                push   <= 1'b0;
            end
            else if (tx_bytes.size() != 0)
            begin
                push    <= 1'b1;
                rx_byte <= tx_bytes.pop_front();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pop replies, with random stall bursts, and check each transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("reply with none pending: command_code %0d angle_arcsec %0d",
                           command_code, angle_arcsec);
                    mismatches++;
                end
                else
                begin
                    head = replies_due.pop_front();
                    if (command_code !== head.code)
                    begin
                        $error("command_code: expected %0d, actual %0d",
                               head.code, command_code);
                        mismatches++;
                    end
                    if (angle_arcsec !== head.angle)
                    begin
                        $error("angle_arcsec: expected %0d, actual %0d",
                               head.angle, angle_arcsec);
                        mismatches++;
                    end
                end
            end
            if (rx_stall != 0)
            begin
                rx_stall <= rx_stall - 1;
                pop      <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                rx_stall <= $urandom_range(0, 7);
                pop      <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, replies_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        queued++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Mostly digits, biased toward the extremes, with some whitespace and stray bytes.
    function automatic logic [7:0] field_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return lx200_pkg::CH_NINE;
        if (r < 25)
            return lx200_pkg::CH_ZERO;
        if (r < 85)
            return lx200_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 93)
            return ($urandom_range(0, 5) == 5) ? lx200_pkg::CH_SPACE
                                               : lx200_pkg::CH_TAB + 8'($urandom_range(0, 4));
        return 8'($urandom_range(0, 255));
    endfunction

    // Coordinate text for set RA ("HH:MM:SS") or set DEC ("sDD*MM:SS"), sometimes
    // cut short, sometimes run past the kept bytes.
    task automatic send_coord(input bit is_dec);
        logic [7:0] txt [0:8];
        int         n;
        int         r;
        bit         nines;
        nines = ($urandom_range(0, 19) == 0);
        n = 0;
        if (is_dec)
        begin
            r = $urandom_range(0, 99);
            txt[n] = (r < 45) ? lx200_pkg::CH_MINUS : (r < 80) ? 8'h2B : field_char();
            n++;
        end
        for (int f = 0; f < 3; f++)
        begin
            if (f != 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    txt[n] = 8'($urandom_range(0, 255));
                else
                    txt[n] = (is_dec && f == 1) ? 8'h2A : lx200_pkg::CH_COLON;
                n++;
            end
            txt[n] = nines ? lx200_pkg::CH_NINE : field_char();
            txt[n + 1] = nines ? lx200_pkg::CH_NINE : field_char();
            n += 2;
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            n = $urandom_range(0, n);
        for (int i = 0; i < n; i++)
            send_byte(txt[i]);
        if (r >= 88)
            repeat ($urandom_range(1, 12)) send_byte(field_char());
    endtask

    // One message of random kind, always closed by the current terminator.
    task automatic send_random_msg();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            send_text(":Sr");
            send_coord(1'b0);
        end
        else if (r < 60)
        begin
            send_text(":Sd");
            send_coord(1'b1);
        end
        else if (r < 75)
        begin
            case ($urandom_range(0, 4))
                0:       send_text(":GR");
                1:       send_text(":GD");
                2:       send_text(":CM");
                3:       send_text(":MS");
                default: send_text(":Q");
            endcase
            if (term_now != lx200_pkg::CH_HASH)
                send_byte(lx200_pkg::CH_HASH);
            if ($urandom_range(0, 9) == 0)
                send_byte(field_char());
        end
        else if (r < 83)
        begin
            // broken prefix
            send_byte(lx200_pkg::CH_COLON);
            case ($urandom_range(0, 4))
                0:       send_byte(lx200_pkg::CH_UP_S);
                1:       send_byte(lx200_pkg::CH_UP_G);
                2:       send_byte(lx200_pkg::CH_UP_C);
                3:       send_byte(lx200_pkg::CH_UP_M);
                default: send_byte(lx200_pkg::CH_UP_Q);
            endcase
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 91)
        begin
            // long message, often past the saturation point
            repeat ($urandom_range(13, 24)) send_byte(field_char());
        end
        else
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(term_now);
    endtask

    task automatic fill(input int nbytes);
        int start;
        start = queued;
        while (queued - start < nbytes)
            send_random_msg();
    endtask

    // Hold until every queued byte is taken and every predicted reply has popped.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (tx_bytes.size() != 0 || push || replies_due.size() != 0);
    endtask

    // Change the terminator only with the parser idle and no message open.
    task automatic set_terminator(input logic [7:0] v);
        wait_drained();
        repeat (LATENCY) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        term_now = v;
    endtask

    task automatic run_phase(input logic [7:0] term, input int pct, input int nbytes);
        set_terminator(term);
        stall_pct = pct;
        fill(nbytes);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every exact command, a short DEC at its negative extreme,
        // and the byte extremes in an unmatched message.
        stall_pct = 15;
        set_terminator(lx200_pkg::CH_HASH);
        send_text(":GR");
        send_byte(term_now);
        send_text(":GD");
        send_byte(term_now);
        send_text(":CM");
        send_byte(term_now);
        send_text(":MS");
        send_byte(term_now);
        send_text(":Q");
        send_byte(term_now);
        send_text(":Sd-99");
        send_byte(term_now);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(term_now);

        // Random: sweep the terminator over its extremes, a whitespace code and a digit.
        run_phase(8'h00, 20, 150);
        run_phase(8'hFF, 40, 150);
        run_phase(8'h0A, 10, 150);
        run_phase(8'h35, 25, 100);
        run_phase(lx200_pkg::CH_HASH, 30, 600);

        // Drain completely once mid-stream, then resume.
        wait_drained();
        stall_pct = 20;
        fill(400);
        while (tx_bytes.size() != 0)
            @(posedge clk);

        // Final stretch runs at full rate on both sides.
        stall_pct = 0;
        fill(200);

        wait_drained();
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
